// ===== rtl/gpc_pkg.sv =====
// gpc_pkg: constants, payload types and helper functions of the gpio pin controller
// no dependencies; imported by every other file of the block

package gpc_pkg;

   localparam int PIN_COUNT     = 54;
   localparam int BANK_BITS     = 32;
   localparam int PAIR_BITS     = 2 * BANK_BITS;
   localparam int CODE_BITS     = 3;
   localparam int PINS_PER_FSEL = 10;
   localparam int FSEL_USED     = PINS_PER_FSEL * CODE_BITS;
   localparam int FSEL_WORDS    = (PIN_COUNT + PINS_PER_FSEL - 1) / PINS_PER_FSEL;
   localparam int FSEL_BITS     = FSEL_WORDS * FSEL_USED;
   localparam int FSEL_IDX_BITS = $clog2(FSEL_WORDS);
   localparam int INDEX_BITS    = 6;
   localparam int PULL_BITS     = 2;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [INDEX_BITS-1:0] W_SET0    = 6'd7;
   localparam logic [INDEX_BITS-1:0] W_SET1    = 6'd8;
   localparam logic [INDEX_BITS-1:0] W_CLR0    = 6'd10;
   localparam logic [INDEX_BITS-1:0] W_CLR1    = 6'd11;
   localparam logic [INDEX_BITS-1:0] W_LEV0    = 6'd13;
   localparam logic [INDEX_BITS-1:0] W_LEV1    = 6'd14;
   localparam logic [INDEX_BITS-1:0] W_PUD     = 6'd37;
   localparam logic [INDEX_BITS-1:0] W_PUDCLK0 = 6'd38;
   localparam logic [INDEX_BITS-1:0] W_PUDCLK1 = 6'd39;

   localparam logic [CODE_BITS-1:0] FUNC_OUTPUT = 3'd1;

   typedef struct packed {
      logic                  opcode;
      logic [INDEX_BITS-1:0] word_index;
      logic [BANK_BITS-1:0]  write_data;
      logic [PIN_COUNT-1:0]  pad_levels;
   } req_item_type;

   typedef struct packed {
      logic [BANK_BITS-1:0] read_data;
      logic [PIN_COUNT-1:0] drive_levels;
      logic [PIN_COUNT-1:0] drive_enables;
      logic [PIN_COUNT-1:0] pull_up_mask;
      logic [PIN_COUNT-1:0] pull_down_mask;
   } rsp_item_type;

   // code bits of a select word that belong to real pins
   function automatic logic [FSEL_USED-1:0] fsel_mask(input logic [FSEL_IDX_BITS-1:0] w);
      logic [FSEL_USED-1:0] m;
      m = '0;
      for (int k = 0; k < PINS_PER_FSEL; k++) begin
         if (int'(w) * PINS_PER_FSEL + k < PIN_COUNT) begin
            m[k*CODE_BITS +: CODE_BITS] = '1;
         end
      end
      return m;
   endfunction

   // place a bank word at its pin positions
   function automatic logic [PIN_COUNT-1:0] bank_place(input logic bank,
                                                       input logic [BANK_BITS-1:0] data);
      logic [PAIR_BITS-1:0] v;
      v = bank ? {data, {BANK_BITS{1'b0}}} : {{BANK_BITS{1'b0}}, data};
      return v[PIN_COUNT-1:0];
   endfunction

   function automatic logic [BANK_BITS-1:0] bank_read(input logic bank,
                                                      input logic [PIN_COUNT-1:0] bits);
      logic [PAIR_BITS-1:0] v;
      v = '0;
      v[PIN_COUNT-1:0] = bits;
      return bank ? v[PAIR_BITS-1:BANK_BITS] : v[BANK_BITS-1:0];
   endfunction

endpackage

// ===== rtl/gpc_if.sv =====
// gpc_req_if / gpc_rsp_if: valid-ready channels of the gpio pin controller
// depends on gpc_pkg for widths

interface gpc_req_if import gpc_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [INDEX_BITS-1:0] word_index;
   logic [BANK_BITS-1:0]  write_data;
   logic [PIN_COUNT-1:0]  pad_levels;

   modport source (output valid, output opcode, output word_index, output write_data,
                   output pad_levels, input ready);
   modport sink   (input valid, input opcode, input word_index, input write_data,
                   input pad_levels, output ready);
endinterface

interface gpc_rsp_if import gpc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BANK_BITS-1:0] read_data;
   logic [PIN_COUNT-1:0] drive_levels;
   logic [PIN_COUNT-1:0] drive_enables;
   logic [PIN_COUNT-1:0] pull_up_mask;
   logic [PIN_COUNT-1:0] pull_down_mask;

   modport source (output valid, output read_data, output drive_levels,
                   output drive_enables, output pull_up_mask, output pull_down_mask,
                   input ready);
   modport sink   (input valid, input read_data, input drive_levels, input drive_enables,
                   input pull_up_mask, input pull_down_mask, output ready);
endinterface

// ===== rtl/gpc_in_stage.sv =====
// gpc_in_stage: input register that holds one bus access until the state stage takes it
// depends on gpc_pkg and gpc_req_if

module gpc_in_stage import gpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   gpc_req_if.sink      req_if,
   input  logic         out_space,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   // the held item moves on whenever the result register has room
   assign req_if.ready = !valid_ff || out_space;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_space) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.opcode     <= req_if.opcode;
         item_ff.word_index <= req_if.word_index;
         item_ff.write_data <= req_if.write_data;
         item_ff.pad_levels <= req_if.pad_levels;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/gpc_regs.sv =====
// gpc_regs: pin controller register file, decodes one access and forms its result
// depends on gpc_pkg

module gpc_regs import gpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [FSEL_BITS-1:0]     codes_ff, codes_in;
   logic [PIN_COUNT-1:0]     latch_ff, latch_in;
   logic [PULL_BITS-1:0]     ctrl_ff, ctrl_in;
   logic [PIN_COUNT-1:0]     pull_hi_ff, pull_hi_in;
   logic [PIN_COUNT-1:0]     pull_lo_ff, pull_lo_in;
   logic [BANK_BITS-1:0]     rd;
   logic [PIN_COUNT-1:0]     pins;
   logic [PIN_COUNT-1:0]     enables;
   logic [FSEL_IDX_BITS-1:0] fidx;
   logic                     is_fsel;

   assign fidx    = item.word_index[FSEL_IDX_BITS-1:0];
   assign is_fsel = item.word_index < INDEX_BITS'(FSEL_WORDS);

   always_comb begin
      codes_in   = codes_ff;
      latch_in   = latch_ff;
      ctrl_in    = ctrl_ff;
      pull_hi_in = pull_hi_ff;
      pull_lo_in = pull_lo_ff;
      rd         = '0;
      pins       = bank_place(item.word_index == W_PUDCLK1, item.write_data);
      if (item.opcode == OP_WRITE) begin
         if (is_fsel) begin
            // bits 30-31 and codes of missing pins are dropped
            codes_in[fidx*FSEL_USED +: FSEL_USED] =
               item.write_data[FSEL_USED-1:0] & fsel_mask(fidx);
         end else begin
            case (item.word_index)
               W_SET0, W_SET1: begin
                  latch_in = latch_ff |
                             bank_place(item.word_index == W_SET1, item.write_data);
               end
               W_CLR0, W_CLR1: begin
                  latch_in = latch_ff &
                             ~bank_place(item.word_index == W_CLR1, item.write_data);
               end
               W_PUD: begin
                  ctrl_in = item.write_data[PULL_BITS-1:0];
               end
               W_PUDCLK0, W_PUDCLK1: begin
                  // pull state kept as two bit planes, code 3 stored as is
                  pull_hi_in = (pull_hi_ff & ~pins) | (pins & {PIN_COUNT{ctrl_ff[1]}});
                  pull_lo_in = (pull_lo_ff & ~pins) | (pins & {PIN_COUNT{ctrl_ff[0]}});
               end
               default: begin
               end
            endcase
         end
      end else begin
         if (is_fsel) begin
            rd = BANK_BITS'(codes_ff[fidx*FSEL_USED +: FSEL_USED]);
         end else begin
            case (item.word_index)
               W_LEV0, W_LEV1: begin
                  rd = bank_read(item.word_index == W_LEV1, item.pad_levels);
               end
               W_PUD: begin
                  rd = BANK_BITS'(ctrl_ff);
               end
               default: begin
                  rd = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      for (int p = 0; p < PIN_COUNT; p++) begin
         enables[p] = codes_in[p*CODE_BITS +: CODE_BITS] == FUNC_OUTPUT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff   <= '0;
         latch_ff   <= '0;
         ctrl_ff    <= '0;
         pull_hi_ff <= '0;
         pull_lo_ff <= '0;
      end else if (load) begin
         codes_ff   <= codes_in;
         latch_ff   <= latch_in;
         ctrl_ff    <= ctrl_in;
         pull_hi_ff <= pull_hi_in;
         pull_lo_ff <= pull_lo_in;
      end
   end

   assign result.read_data      = rd;
   assign result.drive_levels   = latch_in;
   assign result.drive_enables  = enables;
   assign result.pull_up_mask   = pull_hi_in & ~pull_lo_in;
   assign result.pull_down_mask = pull_lo_in & ~pull_hi_in;

endmodule

// ===== rtl/gpc_out_stage.sv =====
// gpc_out_stage: result register that drives the response channel
// depends on gpc_pkg and gpc_rsp_if

module gpc_out_stage import gpc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         space,
   gpc_rsp_if.source    rsp_if
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type result_ff;

   assign space = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_if.valid          = valid_ff;
   assign rsp_if.read_data      = result_ff.read_data;
   assign rsp_if.drive_levels   = result_ff.drive_levels;
   assign rsp_if.drive_enables  = result_ff.drive_enables;
   assign rsp_if.pull_up_mask   = result_ff.pull_up_mask;
   assign rsp_if.pull_down_mask = result_ff.pull_down_mask;

endmodule

// ===== rtl/gpio_pin_controller_core.sv =====
// gpio_pin_controller_core: top level of the gpio pin controller
// depends on gpc_pkg, gpc_if, gpc_in_stage, gpc_regs, gpc_out_stage
//
// usage:
//   req_if carries one bus access per transfer: opcode (0 read, 1 write), word_index,
//   write_data and the sampled pad_levels. rsp_if returns one result per access:
//   read_data (zero for writes and unmapped words) and the pin outputs drive_levels,
//   drive_enables, pull_up_mask and pull_down_mask as they stand after the access.
//   a request is held in the input register, then passes through the register decode into the
//   result register, which drives the response. throughput: one access per cycle while the
//   receiver takes responses, set by the single pass through the register decode between the
//   input register and the result register.
//   reset (synchronous, active high) clears all function codes, the output latch, the
//   pull control and every pull state, and empties both registers.
//   when the receiver stalls, the result register holds its response and the input
//   register still takes one more access; req_if.ready drops once both are full.

module gpio_pin_controller_core import gpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   gpc_req_if.sink   req_if,
   gpc_rsp_if.source rsp_if
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         out_space;
   logic         fire;

   assign fire = item_valid && out_space;

   gpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .out_space  (out_space),
      .item_valid (item_valid),
      .item       (item)
   );

   gpc_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .load   (fire),
      .item   (item),
      .result (result)
   );

   gpc_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (fire),
      .result (result),
      .space  (out_space),
      .rsp_if (rsp_if)
   );

endmodule

// ===== rtl/gpc_checker.sv =====
// gpc_checker: port-level assertions for gpio_pin_controller_core, attached by bind
// depends on gpc_pkg

module gpc_checker import gpc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [BANK_BITS-1:0] rsp_read_data,
   input logic [PIN_COUNT-1:0] rsp_drive_levels,
   input logic [PIN_COUNT-1:0] rsp_pull_up_mask,
   input logic [PIN_COUNT-1:0] rsp_pull_down_mask
);

   // both stages are empty after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("pipeline not empty after reset");

   // a pin never shows pull-up and pull-down at once
   a_pull_disjoint: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_pull_up_mask & rsp_pull_down_mask) == '0))
      else $error("pin in both pull masks");

   // with an empty result register the input side always takes a transfer
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty result register");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_read_data) && $stable(rsp_drive_levels)))
      else $error("response changed while stalled");

endmodule

bind gpio_pin_controller_core gpc_checker u_gpc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_read_data      (rsp_if.read_data),
   .rsp_drive_levels   (rsp_if.drive_levels),
   .rsp_pull_up_mask   (rsp_if.pull_up_mask),
   .rsp_pull_down_mask (rsp_if.pull_down_mask)
);
